@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the rtl controller orsc_ctrl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property, checked on every rising clock outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
   `ASSERT_CLK(label, !(cond), msg)

`endif

@@ sv/orsc_pkg.sv @@
// ----------------------------------------------------------------------------
// orsc_pkg
// shared types and constants of the overwrite ring with sequenced commit
// ----------------------------------------------------------------------------
package orsc_pkg;

   localparam int RING_DEPTH = 32;
   localparam int IDX_W      = $clog2(RING_DEPTH);
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);

   localparam logic [1:0] LEVEL_BAD = 2'd3;

   typedef enum logic [1:0] {
      KIND_WRITE  = 2'd0,
      KIND_PEEK   = 2'd1,
      KIND_COMMIT = 2'd2,
      KIND_BAD    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_INVALID = 2'd1,
      STAT_EMPTY   = 2'd2,
      STAT_STALE   = 2'd3
   } status_type;

   // one stored trace record, sequence kept apart
   typedef struct packed {
      logic        has_field;
      logic        has_result;
      logic [15:0] order_id;
      logic [7:0]  source;
      logic [1:0]  level;
      logic [31:0] result_value;
      logic [31:0] field_value;
   } rec_type;

   typedef struct packed {
      kind_type    kind;
      logic [1:0]  level;
      logic [7:0]  source;
      logic [15:0] order_id;
      logic [31:0] result_value;
      logic [31:0] field_value;
      logic        has_result;
      logic        has_field;
      logic [31:0] commit_sequence;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] sequence_res;
      rec_type     rec;
      logic [5:0]  pending_count;
      logic [31:0] dropped_count;
      logic [5:0]  high_watermark;
   } rsp_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [31:0]      wr_seq;
      rec_type          wr_rec;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic [31:0] seq;
      rec_type     rec;
   } mem_rsp_type;

endpackage

@@ sv/orsc_store.sv @@
// ----------------------------------------------------------------------------
// orsc_store
// ring storage: sequence memory and record memory, one write and one
// registered read port each, shared addresses
// ----------------------------------------------------------------------------
module orsc_store (
   input  logic                 clock,
   input  orsc_pkg::mem_req_type mem_req,
   output orsc_pkg::mem_rsp_type mem_rsp
);
   import orsc_pkg::*;

   logic [31:0] seq_mem [RING_DEPTH];
   rec_type     rec_mem [RING_DEPTH];
   logic [31:0] rd_seq_ff;
   rec_type     rd_rec_ff;

   // entries are read on every accepted request; the data is used only while held, so it was written first
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         seq_mem[mem_req.wr_addr] <= mem_req.wr_seq;
         rec_mem[mem_req.wr_addr] <= mem_req.wr_rec;
      end
      if (mem_req.rd_en) begin
         rd_seq_ff <= seq_mem[mem_req.rd_addr];
         rd_rec_ff <= rec_mem[mem_req.rd_addr];
      end
   end

   assign mem_rsp.seq = rd_seq_ff;
   assign mem_rsp.rec = rd_rec_ff;

endmodule

@@ sv/orsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// orsc_ctrl
// request sequencer: pointers, counters, sequence numbering and result build
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module orsc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  orsc_pkg::req_type     req,
   input  logic                  csr_we,
   input  logic [7:0]            csr_wr_data,
   output logic                  busy,
   output orsc_pkg::mem_req_type mem_req,
   input  orsc_pkg::mem_rsp_type mem_rsp,
   output logic                  rsp_valid,
   output orsc_pkg::rsp_type     rsp
);
   import orsc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [7:0]       src_cnt_ff, src_cnt_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [CNT_W-1:0] peak_ff, peak_in;
   logic [31:0]      next_seq_ff, next_seq_in;
   logic [31:0]      dropped_ff, dropped_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             accept;
   logic [31:0]      seq_inc;
   logic [31:0]      seq_new;
   rec_type          wr_rec;
   logic [IDX_W-1:0] head_nx;
   logic [IDX_W-1:0] tail_nx;

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff == ST_EXEC);
   assign seq_inc = next_seq_ff + 32'd1;
   // sequence zero is never handed out
   assign seq_new = (seq_inc == 32'd0) ? 32'd1 : seq_inc;
   assign head_nx = (head_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
   assign tail_nx = (tail_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : tail_ff + IDX_W'(1);

   // text-only records drop result and field
   always_comb begin
      wr_rec.level        = req_ff.level;
      wr_rec.source       = req_ff.source;
      wr_rec.order_id     = req_ff.order_id;
      wr_rec.has_result   = req_ff.has_result;
      wr_rec.has_field    = req_ff.has_result & req_ff.has_field;
      wr_rec.result_value = req_ff.has_result ? req_ff.result_value : 32'd0;
      wr_rec.field_value  = req_ff.has_result ? req_ff.field_value : 32'd0;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      src_cnt_in   = csr_we ? csr_wr_data : src_cnt_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      held_in      = held_ff;
      peak_in      = peak_ff;
      next_seq_in  = next_seq_ff;
      dropped_in   = dropped_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;

      mem_req         = '0;
      mem_req.rd_en   = accept;
      mem_req.rd_addr = tail_ff;
      mem_req.wr_addr = head_ff;
      mem_req.wr_seq  = seq_new;
      mem_req.wr_rec  = wr_rec;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
               req_in   = req;
            end
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            rsp_in.status = STAT_OK;
            case (req_ff.kind)
               KIND_WRITE: begin
                  if (req_ff.level == LEVEL_BAD || req_ff.source >= src_cnt_ff) begin
                     rsp_in.status = STAT_INVALID;
                  end else begin
                     mem_req.wr_en       = 1'b1;
                     next_seq_in         = seq_new;
                     head_in             = head_nx;
                     rsp_in.sequence_res = seq_new;
                     if (held_ff < CNT_W'(RING_DEPTH)) begin
                        held_in = held_ff + CNT_W'(1);
                     end else begin
                        // full: oldest record is overwritten
                        tail_in    = tail_nx;
                        dropped_in = dropped_ff + 32'd1;
                     end
                  end
               end
               KIND_PEEK: begin
                  if (held_ff == '0) begin
                     rsp_in.status = STAT_EMPTY;
                  end else begin
                     rsp_in.sequence_res = mem_rsp.seq;
                     rsp_in.rec          = mem_rsp.rec;
                  end
               end
               KIND_COMMIT: begin
                  if (held_ff == '0) begin
                     rsp_in.status = STAT_EMPTY;
                  end else if (mem_rsp.seq != req_ff.commit_sequence) begin
                     rsp_in.status = STAT_STALE;
                  end else begin
                     rsp_in.sequence_res = req_ff.commit_sequence;
                     tail_in             = tail_nx;
                     held_in             = held_ff - CNT_W'(1);
                  end
               end
               default: begin
                  rsp_in.status = STAT_INVALID;
               end
            endcase
            if (held_in > peak_ff) begin
               peak_in = held_in;
            end
            rsp_in.pending_count  = 6'(held_in);
            rsp_in.dropped_count  = dropped_in;
            rsp_in.high_watermark = 6'(peak_in);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         src_cnt_ff   <= 8'd1;
         head_ff      <= '0;
         tail_ff      <= '0;
         held_ff      <= '0;
         peak_ff      <= '0;
         next_seq_ff  <= '0;
         dropped_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_cnt_ff   <= src_cnt_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         held_ff      <= held_in;
         peak_ff      <= peak_in;
         next_seq_ff  <= next_seq_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `ASSERT_NEVER(a_held_bound, held_ff > CNT_W'(RING_DEPTH), "held count above ring depth")
   `ASSERT_CLK(a_ptr_match, (held_ff == '0 || held_ff == CNT_W'(RING_DEPTH)) |-> (head_ff == tail_ff), "head and tail disagree with held count")
   `ASSERT_NEVER(a_peak_low, peak_ff < held_ff, "high-water mark below held count")
   `ASSERT_CLK(a_one_rsp, (state_ff == ST_EXEC) |=> (rsp_valid_ff && state_ff == ST_IDLE), "request did not produce one response")
   `ASSERT_NEVER(a_seq_zero, mem_req.wr_en && mem_req.wr_seq == 32'd0, "sequence zero stored")

endmodule

@@ sv/overwrite_ring_with_sequenced_commit_core.sv @@
// ----------------------------------------------------------------------------
// overwrite_ring_with_sequenced_commit_core
// trace-record ring that overwrites the oldest entry when full, with peek
// and sequence-checked commit of the oldest record
// ----------------------------------------------------------------------------
//  channel   ports             handshake
//  request   req_*             start high while busy low
//  response  rsp_*             rsp_valid strobe, one cycle, no backpressure
//  config    csr_we, csr_wr_*  write on csr_we, no wait
//
//  each request is accepted in the idle state, where the tail entry is read
//  from the ring memory, and the execute state that follows updates state and the memory;
//  a response strobe follows in the next cycle; a new request may be
//  accepted during that cycle
//  reset is synchronous and clears pointers and counters; source_count
//  returns to 1; the ring memory is not cleared
// ----------------------------------------------------------------------------
module overwrite_ring_with_sequenced_commit_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [1:0]  req_level,
   input  logic [7:0]  req_source,
   input  logic [15:0] req_order_id,
   input  logic signed [31:0] req_result_value,
   input  logic signed [31:0] req_field_value,
   input  logic        req_has_result,
   input  logic        req_has_field,
   input  logic [31:0] req_commit_sequence,
   input  logic        csr_we,
   input  logic [7:0]  csr_wr_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_sequence_res,
   output logic [1:0]  rsp_out_level,
   output logic [7:0]  rsp_out_source,
   output logic [15:0] rsp_out_order_id,
   output logic signed [31:0] rsp_out_result,
   output logic signed [31:0] rsp_out_field_value,
   output logic        rsp_out_has_result,
   output logic        rsp_out_has_field,
   output logic [5:0]  rsp_pending_count,
   output logic [31:0] rsp_dropped_count,
   output logic [5:0]  rsp_high_watermark
);
   import orsc_pkg::*;

   req_type     req;
   rsp_type     rsp;
   mem_req_type mem_req;
   mem_rsp_type mem_rsp;

   always_comb begin
      req.kind            = kind_type'(req_kind);
      req.level           = req_level;
      req.source          = req_source;
      req.order_id        = req_order_id;
      req.result_value    = req_result_value;
      req.field_value     = req_field_value;
      req.has_result      = req_has_result;
      req.has_field       = req_has_field;
      req.commit_sequence = req_commit_sequence;
   end

   orsc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req         (req),
      .csr_we      (csr_we),
      .csr_wr_data (csr_wr_data),
      .busy        (busy),
      .mem_req     (mem_req),
      .mem_rsp     (mem_rsp),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp)
   );

   orsc_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   assign rsp_status          = rsp.status;
   assign rsp_sequence_res    = rsp.sequence_res;
   assign rsp_out_level       = rsp.rec.level;
   assign rsp_out_source      = rsp.rec.source;
   assign rsp_out_order_id    = rsp.rec.order_id;
   assign rsp_out_result      = rsp.rec.result_value;
   assign rsp_out_field_value = rsp.rec.field_value;
   assign rsp_out_has_result  = rsp.rec.has_result;
   assign rsp_out_has_field   = rsp.rec.has_field;
   assign rsp_pending_count   = rsp.pending_count;
   assign rsp_dropped_count   = rsp.dropped_count;
   assign rsp_high_watermark  = rsp.high_watermark;

endmodule

@@ dv/ring_reply_checker.sv @@
// ----------------------------------------------------------------------------
// ring_reply_checker
// watches the request, response and csr ports of the trace ring, keeps its
// own copy of the ring contents and counters, predicts one response per
// accepted request and compares it field by field in arrival order
// ----------------------------------------------------------------------------
module ring_reply_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [1:0]  req_level,
   input  logic [7:0]  req_source,
   input  logic [15:0] req_order_id,
   input  logic [31:0] req_result_value,
   input  logic [31:0] req_field_value,
   input  logic        req_has_result,
   input  logic        req_has_field,
   input  logic [31:0] req_commit_sequence,
   input  logic        csr_we,
   input  logic [7:0]  csr_wr_data,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_status,
   input  logic [31:0] rsp_sequence_res,
   input  logic [1:0]  rsp_out_level,
   input  logic [7:0]  rsp_out_source,
   input  logic [15:0] rsp_out_order_id,
   input  logic [31:0] rsp_out_result,
   input  logic [31:0] rsp_out_field_value,
   input  logic        rsp_out_has_result,
   input  logic        rsp_out_has_field,
   input  logic [5:0]  rsp_pending_count,
   input  logic [31:0] rsp_dropped_count,
   input  logic [5:0]  rsp_high_watermark,
   output int          mismatch_count,
   output int          awaiting_count,
   output logic [31:0] oldest_sequence
);
   timeunit 1ns;
   timeprecision 1ps;
   import orsc_pkg::*;

   logic [31:0]      seq_ring [RING_DEPTH];
   rec_type          rec_ring [RING_DEPTH];
   logic [IDX_W-1:0] head_pos;
   logic [IDX_W-1:0] tail_pos;
   logic [CNT_W-1:0] held;
   logic [CNT_W-1:0] peak;
   logic [31:0]      last_sequence;
   logic [31:0]      overwritten;
   logic [7:0]       source_limit;
   rsp_type          expected_replies [$];

   initial begin
      mismatch_count  = 0;
      awaiting_count  = 0;
      oldest_sequence = '0;
   end

   function automatic logic [IDX_W-1:0] ring_step(input logic [IDX_W-1:0] pos);
      return (pos == IDX_W'(RING_DEPTH - 1)) ? '0 : pos + 1'b1;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
         mismatch_count++;
      end
   endtask

   // applies one request to the shadow ring and returns the response it owes
   task automatic predict_ring_reply(input req_type rq, output rsp_type rs);
      rec_type rec;
      rs = '0;
      rs.status = STAT_OK;
      case (rq.kind)
         KIND_WRITE: begin
            if (rq.level == LEVEL_BAD || rq.source >= source_limit) begin
               rs.status = STAT_INVALID;
            end else begin
               last_sequence = last_sequence + 1;
               if (last_sequence == '0) begin
                  last_sequence = 32'd1;
               end
               // text-only records drop result, field value and field flag
               rec.level        = rq.level;
               rec.source       = rq.source;
               rec.order_id     = rq.order_id;
               rec.has_result   = rq.has_result;
               rec.has_field    = rq.has_result & rq.has_field;
               rec.result_value = rq.has_result ? rq.result_value : '0;
               rec.field_value  = rq.has_result ? rq.field_value : '0;
               seq_ring[head_pos] = last_sequence;
               rec_ring[head_pos] = rec;
               head_pos = ring_step(head_pos);
               if (held < CNT_W'(RING_DEPTH)) begin
                  held = held + 1'b1;
               end else begin
                  tail_pos    = ring_step(tail_pos);
                  overwritten = overwritten + 1;
               end
               if (held > peak) begin
                  peak = held;
               end
               rs.sequence_res = last_sequence;
            end
         end
         KIND_PEEK: begin
            if (held == '0) begin
               rs.status = STAT_EMPTY;
            end else begin
               rs.sequence_res = seq_ring[tail_pos];
               rs.rec          = rec_ring[tail_pos];
            end
         end
         KIND_COMMIT: begin
            if (held == '0) begin
               rs.status = STAT_EMPTY;
            end else if (seq_ring[tail_pos] != rq.commit_sequence) begin
               rs.status = STAT_STALE;
            end else begin
               rs.sequence_res = rq.commit_sequence;
               tail_pos = ring_step(tail_pos);
               held     = held - 1'b1;
            end
         end
         default: begin
            rs.status = STAT_INVALID;
         end
      endcase
      rs.pending_count  = held;
      rs.dropped_count  = overwritten;
      rs.high_watermark = peak;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      req_type rq;
      if (reset) begin
         for (int i = 0; i < RING_DEPTH; i++) begin
            seq_ring[i] = '0;
         end
         head_pos      = '0;
         tail_pos      = '0;
         held          = '0;
         peak          = '0;
         last_sequence = '0;
         overwritten   = '0;
         source_limit  = 8'd1;
         expected_replies.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_replies.size() == 0) begin
               $error("response with no request outstanding");
               mismatch_count++;
            end else begin
               want = expected_replies.pop_front();
               compare_field("status", want.status, rsp_status);
               compare_field("sequence_res", want.sequence_res, rsp_sequence_res);
               compare_field("out_level", want.rec.level, rsp_out_level);
               compare_field("out_source", want.rec.source, rsp_out_source);
               compare_field("out_order_id", want.rec.order_id, rsp_out_order_id);
               compare_field("out_result", want.rec.result_value, rsp_out_result);
               compare_field("out_field_value", want.rec.field_value,
                             rsp_out_field_value);
               compare_field("out_has_result", want.rec.has_result, rsp_out_has_result);
               compare_field("out_has_field", want.rec.has_field, rsp_out_has_field);
               compare_field("pending_count", want.pending_count, rsp_pending_count);
               compare_field("dropped_count", want.dropped_count, rsp_dropped_count);
               compare_field("high_watermark", want.high_watermark,
                             rsp_high_watermark);
            end
         end
         if (csr_we) begin
            source_limit = csr_wr_data;
         end
         if (start && !busy) begin
            rq.kind            = kind_type'(req_kind);
            rq.level           = req_level;
            rq.source          = req_source;
            rq.order_id        = req_order_id;
            rq.result_value    = req_result_value;
            rq.field_value     = req_field_value;
            rq.has_result      = req_has_result;
            rq.has_field       = req_has_field;
            rq.commit_sequence = req_commit_sequence;
            predict_ring_reply(rq, want);
            expected_replies.push_back(want);
         end
      end
      awaiting_count  = expected_replies.size();
      oldest_sequence = seq_ring[tail_pos];
   end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// drives requests and source_count writes into the trace ring: a directed
// pass over the error and corner cases, then random fill and drain runs
// under several csr settings and sender gap rates; the checker judges
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import orsc_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_kind;
   logic [1:0]  req_level;
   logic [7:0]  req_source;
   logic [15:0] req_order_id;
   logic [31:0] req_result_value;
   logic [31:0] req_field_value;
   logic        req_has_result;
   logic        req_has_field;
   logic [31:0] req_commit_sequence;
   logic        csr_we;
   logic [7:0]  csr_wr_data;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_sequence_res;
   logic [1:0]  rsp_out_level;
   logic [7:0]  rsp_out_source;
   logic [15:0] rsp_out_order_id;
   logic [31:0] rsp_out_result;
   logic [31:0] rsp_out_field_value;
   logic        rsp_out_has_result;
   logic        rsp_out_has_field;
   logic [5:0]  rsp_pending_count;
   logic [31:0] rsp_dropped_count;
   logic [5:0]  rsp_high_watermark;
   int          mismatch_count;
   int          awaiting_count;
   logic [31:0] oldest_sequence;
   logic [7:0]  source_limit;

   overwrite_ring_with_sequenced_commit_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_level           (req_level),
      .req_source          (req_source),
      .req_order_id        (req_order_id),
      .req_result_value    (req_result_value),
      .req_field_value     (req_field_value),
      .req_has_result      (req_has_result),
      .req_has_field       (req_has_field),
      .req_commit_sequence (req_commit_sequence),
      .csr_we              (csr_we),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_sequence_res    (rsp_sequence_res),
      .rsp_out_level       (rsp_out_level),
      .rsp_out_source      (rsp_out_source),
      .rsp_out_order_id    (rsp_out_order_id),
      .rsp_out_result      (rsp_out_result),
      .rsp_out_field_value (rsp_out_field_value),
      .rsp_out_has_result  (rsp_out_has_result),
      .rsp_out_has_field   (rsp_out_has_field),
      .rsp_pending_count   (rsp_pending_count),
      .rsp_dropped_count   (rsp_dropped_count),
      .rsp_high_watermark  (rsp_high_watermark)
   );

   ring_reply_checker i_reply_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_level           (req_level),
      .req_source          (req_source),
      .req_order_id        (req_order_id),
      .req_result_value    (req_result_value),
      .req_field_value     (req_field_value),
      .req_has_result      (req_has_result),
      .req_has_field       (req_has_field),
      .req_commit_sequence (req_commit_sequence),
      .csr_we              (csr_we),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_sequence_res    (rsp_sequence_res),
      .rsp_out_level       (rsp_out_level),
      .rsp_out_source      (rsp_out_source),
      .rsp_out_order_id    (rsp_out_order_id),
      .rsp_out_result      (rsp_out_result),
      .rsp_out_field_value (rsp_out_field_value),
      .rsp_out_has_result  (rsp_out_has_result),
      .rsp_out_has_field   (rsp_out_has_field),
      .rsp_pending_count   (rsp_pending_count),
      .rsp_dropped_count   (rsp_dropped_count),
      .rsp_high_watermark  (rsp_high_watermark),
      .mismatch_count      (mismatch_count),
      .awaiting_count      (awaiting_count),
      .oldest_sequence     (oldest_sequence)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("overwrite_ring_with_sequenced_commit_core: mismatch");
      $finish;
   end

   function automatic req_type mk(input kind_type k, input logic [1:0] lv,
                                  input logic [7:0] src, input logic [15:0] ord,
                                  input logic [31:0] rv, input logic [31:0] fv,
                                  input logic hr, input logic hf,
                                  input logic [31:0] cs);
      req_type rq;
      rq.kind            = k;
      rq.level           = lv;
      rq.source          = src;
      rq.order_id        = ord;
      rq.result_value    = rv;
      rq.field_value     = fv;
      rq.has_result      = hr;
      rq.has_field       = hf;
      rq.commit_sequence = cs;
      return rq;
   endfunction

   // aim: commit against the oldest held sequence plus skew, resolved at drive
   // time so it reflects every request accepted so far
   task automatic issue(input req_type rq, input bit aim, input logic [31:0] skew);
      @(negedge clock);
      if (aim) begin
         rq.commit_sequence = oldest_sequence + skew;
      end
      req_kind            <= rq.kind;
      req_level           <= rq.level;
      req_source          <= rq.source;
      req_order_id        <= rq.order_id;
      req_result_value    <= rq.result_value;
      req_field_value     <= rq.field_value;
      req_has_result      <= rq.has_result;
      req_has_field       <= rq.has_field;
      req_commit_sequence <= rq.commit_sequence;
      start               <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // sender holds off until the ring has answered everything, then rewrites
   task automatic write_source_limit(input logic [7:0] value);
      @(negedge clock);
      start <= 1'b0;
      while (awaiting_count != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_wr_data <= value;
      csr_we      <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      source_limit = value;
   endtask

   task automatic roll_request(input bit filling, output req_type rq,
                               output bit aim, output logic [31:0] skew);
      int pick;
      pick = $urandom_range(99);
      rq = mk(KIND_WRITE, 2'($urandom_range(2)), 8'($urandom), 16'($urandom),
              $urandom, $urandom, 1'($urandom), 1'($urandom), $urandom);
      aim  = 1'b0;
      skew = '0;
      if (pick < 2) begin
         rq.kind = KIND_BAD;
      end else if (pick < (filling ? 72 : 25)) begin
         rq.kind = KIND_WRITE;
      end else if (pick < (filling ? 86 : 45)) begin
         rq.kind = KIND_PEEK;
      end else begin
         rq.kind = KIND_COMMIT;
      end
      if ($urandom_range(99) < 8) begin
         rq.level = LEVEL_BAD;
      end
      if (source_limit != 0) begin
         if ($urandom_range(99) < 8) begin
            rq.source = 8'($urandom_range(255, source_limit));
         end else begin
            rq.source = 8'($urandom_range(source_limit - 1, 0));
         end
      end
      case ($urandom_range(9))
         0: rq.order_id = '0;
         1: rq.order_id = 16'hFFFF;
         2: rq.result_value = 32'h8000_0000;
         3: rq.field_value = 32'h7FFF_FFFF;
         default: ;
      endcase
      pick = $urandom_range(99);
      if (pick < 85) begin
         aim = 1'b1;
      end else if (pick < 92) begin
         aim  = 1'b1;
         skew = $urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF;
      end
   endtask

   // alternating fill and drain runs so the ring both wraps over and empties
   task automatic random_phase(input int count, input int idle_pct);
      req_type     rq;
      bit          aim;
      logic [31:0] skew;
      bit          filling;
      int          run_left;
      filling  = 1'b1;
      run_left = $urandom_range(80, 20);
      repeat (count) begin
         if (run_left == 0) begin
            filling  = !filling;
            run_left = $urandom_range(80, 20);
         end
         run_left--;
         roll_request(filling, rq, aim, skew);
         if ($urandom_range(99) < idle_pct) begin
            @(negedge clock);
            start <= 1'b0;
            repeat ($urandom_range(3)) @(negedge clock);
         end
         issue(rq, aim, skew);
      end
   endtask

   initial begin
      reset               = 1'b1;
      start               = 1'b0;
      req_kind            = KIND_WRITE;
      req_level           = '0;
      req_source          = '0;
      req_order_id        = '0;
      req_result_value    = '0;
      req_field_value     = '0;
      req_has_result      = 1'b0;
      req_has_field       = 1'b0;
      req_commit_sequence = '0;
      csr_we              = 1'b0;
      csr_wr_data         = '0;
      source_limit        = 8'd1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // empty ring, unknown kind and rejected writes under the reset limit
      issue(mk(KIND_PEEK, 2'd0, 8'd0, 16'd0, '0, '0, 1'b0, 1'b0, '0), 1'b0, '0);
      issue(mk(KIND_COMMIT, 2'd0, 8'd0, 16'd0, '0, '0, 1'b0, 1'b0, '0), 1'b0, '0);
      issue(mk(KIND_BAD, 2'd1, 8'd0, 16'd7, '0, '0, 1'b1, 1'b1, '0), 1'b0, '0);
      issue(mk(KIND_WRITE, LEVEL_BAD, 8'd0, 16'd1, 32'd5, 32'd6, 1'b1, 1'b1, '0),
            1'b0, '0);
      issue(mk(KIND_WRITE, 2'd0, 8'd1, 16'd1, 32'd5, 32'd6, 1'b1, 1'b1, '0),
            1'b0, '0);
      // text-only record, then a field value stored without its flag
      issue(mk(KIND_WRITE, 2'd0, 8'd0, 16'd0, 32'h1234_5678, 32'hFFFF_FFFF,
               1'b0, 1'b1, '0), 1'b0, '0);
      issue(mk(KIND_WRITE, 2'd2, 8'd0, 16'h1234, 32'hFFFF_FFFB, 32'h0000_55AA,
               1'b1, 1'b0, '0), 1'b0, '0);

      write_source_limit(8'd255);
      issue(mk(KIND_WRITE, 2'd1, 8'd254, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               1'b1, 1'b1, '0), 1'b0, '0);
      issue(mk(KIND_WRITE, 2'd2, 8'd255, 16'd3, 32'd1, 32'd2, 1'b1, 1'b1, '0),
            1'b0, '0);
      issue(mk(KIND_PEEK, 2'd0, 8'd0, 16'd0, '0, '0, 1'b0, 1'b0, '0), 1'b0, '0);
      // stale sequence first, then the matching one
      issue(mk(KIND_COMMIT, 2'd0, 8'd0, 16'd0, '0, '0, 1'b0, 1'b0, '0), 1'b1, 32'd1);
      issue(mk(KIND_COMMIT, 2'd0, 8'd0, 16'd0, '0, '0, 1'b0, 1'b0, '0), 1'b1, '0);
      issue(mk(KIND_PEEK, 2'd0, 8'd0, 16'd0, '0, '0, 1'b0, 1'b0, '0), 1'b0, '0);
      issue(mk(KIND_COMMIT, 2'd0, 8'd0, 16'd0, '0, '0, 1'b0, 1'b0, '0), 1'b1, '0);
      issue(mk(KIND_COMMIT, 2'd0, 8'd0, 16'd0, '0, '0, 1'b0, 1'b0, '0), 1'b1, '0);
      issue(mk(KIND_PEEK, 2'd0, 8'd0, 16'd0, '0, '0, 1'b0, 1'b0, '0), 1'b0, '0);
      issue(mk(KIND_COMMIT, 2'd0, 8'd0, 16'd0, '0, '0, 1'b0, 1'b0, 32'hFFFF_FFFF),
            1'b0, '0);

      random_phase(360, 0);
      write_source_limit(8'd1);
      random_phase(360, 66);
      // a zero limit turns every write away
      write_source_limit(8'd0);
      random_phase(20, 0);
      write_source_limit(8'($urandom_range(254, 2)));
      random_phase(360, 0);
      write_source_limit(8'($urandom_range(255, 1)));
      random_phase(350, 33);

      @(negedge clock);
      start <= 1'b0;
      while (awaiting_count != 0) @(negedge clock);
      repeat (5) @(posedge clock);
      if (mismatch_count == 0 && awaiting_count == 0) begin
         $display("overwrite_ring_with_sequenced_commit_core: match");
      end else begin
         $display("overwrite_ring_with_sequenced_commit_core: mismatch");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/orsc_pkg.sv
sv/orsc_store.sv
sv/orsc_ctrl.sv
sv/overwrite_ring_with_sequenced_commit_core.sv
dv/ring_reply_checker.sv
dv/testbench.sv
